### rtl/core/webp_header_pixel_count_defines.svh
// Assertion macros for the WebP header pixel counter top level.
`ifndef WEBP_HEADER_PIXEL_COUNT_DEFINES_SVH
`define WEBP_HEADER_PIXEL_COUNT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge.
`define WHPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on the rising clock edge.
`define WHPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WHPC_ASSERT_SAME(label, clk, rst, ante, cons)
`define WHPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/webp_hdr_pkg.sv
// Shared types and constants for the WebP header pixel counter.
package webp_hdr_pkg;

  localparam int BYTE_W  = 8;
  localparam int DIM_W   = 25;
  localparam int COUNT_W = 49;
  localparam int HDR_LEN = 30;
  localparam int POS_W   = 5;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Chunk tags, first file byte in the top bits
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WEBP = "WEBP";
  localparam logic [31:0] TAG_VP8X = "VP8X";
  localparam logic [31:0] TAG_VP8L = "VP8L";
  localparam logic [31:0] TAG_VP8  = "VP8 ";

  // Signature bytes
  localparam logic [7:0] VP8L_SIG   = 8'h2F;
  localparam logic [7:0] VP8_SYNC_0 = 8'h9D;
  localparam logic [7:0] VP8_SYNC_1 = 8'h01;
  localparam logic [7:0] VP8_SYNC_2 = 8'h2A;

  localparam int DIM14_W = 14;

  // One classified header, passed from the front end to the multiply stage
  typedef struct packed {
    logic             status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } hdr_result_t;

endpackage

### rtl/core/webp_hdr_front.sv
// Front end: byte capture, position count and header classification.
module webp_hdr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output logic                      push_valid,
  input  logic                      push_ready,
  output webp_hdr_pkg::hdr_result_t push_data
);
  import webp_hdr_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] store [HDR_LEN];
  logic [BYTE_W-1:0] view  [HDR_LEN];
  logic              accept;
  logic              have_hdr;

  assign s_ready    = push_ready;
  assign accept     = s_valid && push_ready;
  assign push_valid = accept && last_byte;

  // Position count, saturating at the header length; cleared by the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos <= '0;
      end else if (pos < POS_W'(HDR_LEN)) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // Header capture
  always_ff @(posedge clk) begin
    if (accept && (pos < POS_W'(HDR_LEN))) begin
      store[pos] <= data_byte;
    end
  end

  // Header as it stands including the word on the bus
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      view[i] = (pos == POS_W'(i)) ? data_byte : store[i];
    end
  end

  assign have_hdr = (pos >= POS_W'(HDR_LEN - 1));

  // Classification and dimension decode
  always_comb begin
    logic [31:0]        riff, webp, tag, vp8l_bits;
    logic [DIM14_W-1:0] w14, h14;
    logic               ok;
    logic [DIM_W-1:0]   w, h;
    riff      = {view[0], view[1], view[2], view[3]};
    webp      = {view[8], view[9], view[10], view[11]};
    tag       = {view[12], view[13], view[14], view[15]};
    vp8l_bits = {view[24], view[23], view[22], view[21]};
    w14       = '0;
    h14       = '0;
    ok        = 1'b0;
    w         = '0;
    h         = '0;
    if (tag == TAG_VP8X) begin
      ok = 1'b1;
      w  = {1'b0, view[26], view[25], view[24]} + DIM_W'(1);
      h  = {1'b0, view[29], view[28], view[27]} + DIM_W'(1);
    end else if (tag == TAG_VP8L) begin
      ok  = (view[20] == VP8L_SIG);
      w14 = vp8l_bits[DIM14_W-1:0];
      h14 = vp8l_bits[2*DIM14_W-1:DIM14_W];
      w   = DIM_W'(w14) + DIM_W'(1);
      h   = DIM_W'(h14) + DIM_W'(1);
    end else if (tag == TAG_VP8) begin
      ok  = (view[23] == VP8_SYNC_0) && (view[24] == VP8_SYNC_1) &&
            (view[25] == VP8_SYNC_2);
      w14 = {view[27][5:0], view[26]};
      h14 = {view[29][5:0], view[28]};
      w   = DIM_W'(w14);
      h   = DIM_W'(h14);
    end
    ok = ok && have_hdr && (riff == TAG_RIFF) && (webp == TAG_WEBP) &&
         (w != '0) && (h != '0);
    push_data.status = ok ? STATUS_OK : STATUS_FAIL;
    push_data.width  = ok ? w : '0;
    push_data.height = ok ? h : '0;
  end

endmodule

### rtl/core/webp_hdr_queue.sv
// Short result queue between the front end and the multiply stage.
module webp_hdr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_valid,
  output logic                      wr_ready,
  input  webp_hdr_pkg::hdr_result_t wr_data,
  output logic                      rd_valid,
  input  logic                      rd_ready,
  output webp_hdr_pkg::hdr_result_t rd_data
);
  import webp_hdr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdr_result_t      entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entry[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/core/webp_hdr_back.sv
// Back end: width times height into the output register.
module webp_hdr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  webp_hdr_pkg::hdr_result_t           q_data,
  output logic                                m_valid,
  input  logic                                m_ready,
  output logic                                status,
  output logic [webp_hdr_pkg::DIM_W-1:0]      image_width,
  output logic [webp_hdr_pkg::DIM_W-1:0]      image_height,
  output logic [webp_hdr_pkg::COUNT_W-1:0]    pixel_count
);
  import webp_hdr_pkg::*;

  logic [2*DIM_W-1:0] product;

  assign q_ready = !m_valid || m_ready;
  assign product = q_data.width * q_data.height;

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (q_ready) begin
      m_valid <= q_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      status       <= q_data.status;
      image_width  <= q_data.width;
      image_height <= q_data.height;
      pixel_count  <= product[COUNT_W-1:0];
    end
  end

endmodule

### rtl/core/webp_header_pixel_count.sv
// m_axis_tvalid rises once a file's result has passed the queue and the output register.
// Throughput: one byte word per clock, a result per clock from the 25x25 multiply stage;
// input stalls only when the queue (QUEUE_DEPTH entries) is full, output on m_axis_tready.
// Reset (rst, synchronous) clears the position count, the queue and the output valid;
// the 30-byte header store is not cleared and is always refilled before it is read.
module webp_header_pixel_count #(
  parameter int QUEUE_DEPTH = 4  // 2 or more
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [24:0] image_width, [49:25] image_height,
                                       // [98:50] pixel_count, [103:99] zero
  output logic         m_axis_tuser    // status
);
  import webp_hdr_pkg::*;

`include "webp_header_pixel_count_defines.svh"

  hdr_result_t        push_data, q_data;
  logic               push_valid, push_ready;
  logic               q_valid, q_ready;
  logic [DIM_W-1:0]   image_width, image_height;
  logic [COUNT_W-1:0] pixel_count;

  webp_hdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .data_byte  (s_axis_tdata),
    .last_byte  (s_axis_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  webp_hdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  webp_hdr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .m_valid      (m_axis_tvalid),
    .m_ready      (m_axis_tready),
    .status       (m_axis_tuser),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_count  (pixel_count)
  );

  // Output word packing
  assign m_axis_tdata = {5'b0, pixel_count, image_height, image_width};

  // A rejected file carries all-zero dimensions and count
  `WHPC_ASSERT_SAME(a_fail_zero, clk, rst,
    m_axis_tvalid && (m_axis_tuser == STATUS_FAIL), m_axis_tdata == '0)
  // An accepted header never has a zero dimension
  `WHPC_ASSERT_SAME(a_ok_nonzero, clk, rst,
    m_axis_tvalid && (m_axis_tuser == STATUS_OK),
    (image_width != '0) && (image_height != '0) && (pixel_count != '0))
  // A closed file is queued for the back end on the next clock
  `WHPC_ASSERT_NEXT(a_last_queued, clk, rst,
    s_axis_tvalid && s_axis_tready && s_axis_tlast, q_valid)

endmodule

### verif/tb.sv
// Testbench for the WebP header pixel counter: directed and random files checked word by word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import webp_hdr_pkg::*;

  // One expected result word
  typedef struct {
    logic               status;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COUNT_W-1:0] count;
  } pixel_result_t;

  // Tracks the header bytes of the current file and the results still owed
  class pixel_count_board;
    logic [BYTE_W-1:0] header [HDR_LEN];
    int unsigned       position;
    pixel_result_t     expected_q[$];
    int unsigned       errors;

    function new();
      position = 0;
      errors   = 0;
      foreach (header[i]) header[i] = '0;
    endfunction

    // Four stored bytes as a tag, first byte in the top bits
    function logic [31:0] tag_at(int at);
      return {header[at], header[at+1], header[at+2], header[at+3]};
    endfunction

    // Take one accepted byte word; on the last byte, decode the header
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      pixel_result_t r;
      logic [31:0]   bits;
      if (position < HDR_LEN) begin
        header[position] = b;
        position++;
      end
      if (!last) return;
      r = '{STATUS_FAIL, '0, '0, '0};
      if (position == HDR_LEN && tag_at(0) == TAG_RIFF && tag_at(8) == TAG_WEBP) begin
        r.status = STATUS_OK;
        if (tag_at(12) == TAG_VP8X) begin
          r.width  = DIM_W'({header[26], header[25], header[24]}) + 1'b1;
          r.height = DIM_W'({header[29], header[28], header[27]}) + 1'b1;
        end else if (tag_at(12) == TAG_VP8L && header[20] == VP8L_SIG) begin
          bits     = {header[24], header[23], header[22], header[21]};
          r.width  = DIM_W'(bits[DIM14_W-1:0]) + 1'b1;
          r.height = DIM_W'(bits[2*DIM14_W-1:DIM14_W]) + 1'b1;
        end else if (tag_at(12) == TAG_VP8 && header[23] == VP8_SYNC_0 &&
                     header[24] == VP8_SYNC_1 && header[25] == VP8_SYNC_2) begin
          // scale bits in the top two bits of each field are dropped
          bits     = {header[29], header[28], header[27], header[26]};
          r.width  = DIM_W'(bits[DIM14_W-1:0]);
          r.height = DIM_W'(bits[16+DIM14_W-1:16]);
        end else begin
          r.status = STATUS_FAIL;
        end
        if (r.width == 0 || r.height == 0) r.status = STATUS_FAIL;
      end
      if (r.status == STATUS_FAIL) begin
        r.width  = '0;
        r.height = '0;
        r.count  = '0;
      end else begin
        r.count = COUNT_W'(r.width) * COUNT_W'(r.height);
      end
      expected_q.push_back(r);
      position = 0;
    endfunction

    function void compare(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Check one result word against the oldest pending file
    function void check_result(logic status, logic [103:0] data);
      pixel_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no file pending: status %0d, data %h", status, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("status", COUNT_W'(e.status), COUNT_W'(status));
      compare("image_width", COUNT_W'(e.width), COUNT_W'(data[24:0]));
      compare("image_height", COUNT_W'(e.height), COUNT_W'(data[49:25]));
      compare("pixel_count", e.count, data[98:50]);
      compare("tdata padding", '0, COUNT_W'(data[103:99]));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;

  pixel_count_board board = new();

  logic [7:0]  hdr [HDR_LEN];  // header of the file being built
  int unsigned bytes_sent = 0;
  int unsigned src_idle_pct = 7;
  int unsigned sink_idle_pct = 7;

  webp_header_pixel_count dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Result side: random stalls, check every accepted word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tuser, m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Header building
  function void put_tag(int at, logic [31:0] tag);
    for (int i = 0; i < 4; i++) hdr[at+i] = tag[31-8*i -: 8];
  endfunction

  function void start_header(logic [31:0] tag);
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    put_tag(0, TAG_RIFF);
    put_tag(8, TAG_WEBP);
    put_tag(12, tag);
  endfunction

  function void set_vp8x(logic [23:0] w_m1, logic [23:0] h_m1);
    for (int i = 0; i < 3; i++) begin
      hdr[24+i] = w_m1[8*i +: 8];
      hdr[27+i] = h_m1[8*i +: 8];
    end
  endfunction

  function void set_vp8l(logic [31:0] bits);
    hdr[20] = VP8L_SIG;
    for (int i = 0; i < 4; i++) hdr[21+i] = bits[8*i +: 8];
  endfunction

  function void set_vp8(logic [15:0] w_field, logic [15:0] h_field);
    hdr[23] = VP8_SYNC_0;
    hdr[24] = VP8_SYNC_1;
    hdr[25] = VP8_SYNC_2;
    for (int i = 0; i < 2; i++) begin
      hdr[26+i] = w_field[8*i +: 8];
      hdr[28+i] = h_field[8*i +: 8];
    end
  endfunction

  // Random values weighted toward the extremes
  function logic [23:0] pick24();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  function logic [31:0] pick32();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function logic [15:0] pick16();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hC000;  // scale bits only, zero size
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one byte word, with random gaps before it
  task send_word(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  // Header bytes first, random bytes past the header
  task send_file(int len);
    for (int i = 0; i < len; i++) begin
      send_word((i < HDR_LEN) ? hdr[i] : 8'($urandom), i == len - 1);
    end
  endtask

  // Mostly well-formed files, a quarter broken in some way
  task send_random_file();
    int pick;
    int len;
    int pos;
    pick = $urandom_range(99);
    len  = ($urandom_range(3) == 0) ? HDR_LEN + $urandom_range(1, 20) : HDR_LEN;
    case ($urandom_range(2))
      0:       begin start_header(TAG_VP8X); set_vp8x(pick24(), pick24()); end
      1:       begin start_header(TAG_VP8L); set_vp8l(pick32()); end
      default: begin start_header(TAG_VP8); set_vp8(pick16(), pick16()); end
    endcase
    if (pick >= 75) begin
      case ($urandom_range(3))
        0: len = $urandom_range(1, HDR_LEN - 1);
        1: begin
          // corrupt a tag or signature byte; the size bytes map onto signatures
          pos = $urandom_range(15);
          if (pos == 4) pos = 20;
          else if (pos > 4 && pos < 8) pos = pos + 18;
          hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
        end
        2:       put_tag(12, $urandom);
        default: foreach (hdr[i]) hdr[i] = 8'($urandom);
      endcase
    end
    send_file(len);
  endtask

  // Main sequence
  initial begin
    int files;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // extended header, largest and smallest sizes
    start_header(TAG_VP8X); set_vp8x('1, '1); send_file(HDR_LEN);
    start_header(TAG_VP8X); set_vp8x('0, '0); send_file(HDR_LEN);
    // lossless, all ones and all zeros, then a bad signature
    start_header(TAG_VP8L); set_vp8l('1); send_file(HDR_LEN);
    start_header(TAG_VP8L); set_vp8l('0); send_file(HDR_LEN);
    start_header(TAG_VP8L); set_vp8l($urandom); hdr[20] = ~VP8L_SIG; send_file(HDR_LEN);
    // lossy: scale bits dropped, zero width, zero height, broken sync
    start_header(TAG_VP8); set_vp8('1, '1); send_file(HDR_LEN);
    start_header(TAG_VP8); set_vp8(16'h0000, 16'h1234); send_file(HDR_LEN);
    start_header(TAG_VP8); set_vp8(16'h0100, 16'hC000); send_file(HDR_LEN);
    start_header(TAG_VP8); set_vp8(16'h0200, 16'h0300); hdr[24] = 8'h00; send_file(HDR_LEN);
    // short files, then a file longer than the header
    start_header(TAG_VP8X); set_vp8x(24'h10, 24'h20); send_file(HDR_LEN - 1);
    send_file(1);
    start_header(TAG_VP8X); set_vp8x(24'h123456, 24'h0000FF); send_file(HDR_LEN + 15);
    // bad container tags and an unknown chunk
    start_header(TAG_VP8X); hdr[3] = 8'h00; send_file(HDR_LEN);
    start_header(TAG_VP8L); set_vp8l($urandom); hdr[11] = 8'h00; send_file(HDR_LEN);
    start_header("VP9 "); send_file(HDR_LEN);

    // random files, with one stretch free of stalls on both sides
    files = 0;
    while (bytes_sent < 850) begin
      if (files == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (files == 9) begin
        src_idle_pct  = 7;
        sink_idle_pct = 7;
      end
      send_random_file();
      files++;
    end
    s_axis_tvalid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/webp_hdr_pkg.sv
rtl/core/webp_hdr_front.sv
rtl/core/webp_hdr_queue.sv
rtl/core/webp_hdr_back.sv
rtl/core/webp_header_pixel_count.sv
verif/tb.sv
